// File: design/fcd_pkg.sv
`timescale 1ns / 1ps
// Package for the circular-delay FIR filter: payload widths, request codes,
// Q1.15 limits and the sequencer state type. Depends on nothing.
package fcd_pkg;

	localparam int VALUE_W = 16;
	localparam int INDEX_W = 5;
	localparam int FRAC_W  = 15;

	localparam logic signed [VALUE_W-1:0] Q_MAX = 16'sh7FFF;
	localparam logic signed [VALUE_W-1:0] Q_MIN = 16'sh8000;

	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_COEF   = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RUN   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

endpackage

// File: design/fcd_req_if.sv
`timescale 1ns / 1ps
// Request channel of the FIR filter: valid/ready plus sample or coefficient.
// Depends on fcd_pkg for payload widths.
interface fcd_req_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 req_type;
	logic [fcd_pkg::INDEX_W-1:0]          tap_index;
	logic signed [fcd_pkg::VALUE_W-1:0]   value;

	modport source (output valid, req_type, tap_index, value, input ready);
	modport sink   (input valid, req_type, tap_index, value, output ready);
endinterface

// File: design/fcd_res_if.sv
`timescale 1ns / 1ps
// Result channel of the FIR filter: valid/ready plus filtered output and flag.
// Depends on fcd_pkg for payload widths.
interface fcd_res_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [fcd_pkg::VALUE_W-1:0]   filtered;
	logic                                 saturated;

	modport source (output valid, filtered, saturated, input ready);
	modport sink   (input valid, filtered, saturated, output ready);
endinterface

// File: design/fcd_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for the sample line and the coefficient table.
module fcd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 21
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: design/fir_filter_circular_delay.sv
`timescale 1ns / 1ps
// FIR filter with a circular delay line and one shared multiply-accumulate.
// Depends on fcd_pkg, fcd_req_if, fcd_res_if and fcd_ram.
//
// Usage:
//   req carries either a Q1.15 sample (req_type = sample) or a coefficient
//   write (req_type = coefficient, tap_index selects the tap; an index at or
//   beyond TAPS is dropped). A transfer happens when valid and ready are high.
//   A coefficient write gives no result. A sample is written to the delay
//   line, then the multiply-accumulate walks the delay line from oldest to
//   newest sample, the read and multiply stages drain, and the result is
//   loaded into the output register, which raises res.valid. req.ready is
//   high only while the sequencer is idle, so a new sample is taken only
//   after the last result has been loaded into the output register; this
//   follows from the single multiplier and the single read port per RAM.
//   res holds one result in an output register; a new sample may be taken
//   while it waits, and the next result waits in the final state until the
//   receiver frees the register.
//   Reset (arst_n low) clears the delay line and coefficients to zero through
//   per-entry valid bits, the write pointer and all control state; the block
//   is ready in the first cycle after reset.
module fir_filter_circular_delay #(
	parameter int TAPS = 21
) (
	input  logic         clk,
	input  logic         arst_n,
	fcd_req_if.sink      req,
	fcd_res_if.source    res
);

	localparam int AW     = $clog2(TAPS);
	localparam int PROD_W = 2 * fcd_pkg::VALUE_W;
	localparam int ACC_W  = PROD_W + $clog2(TAPS);
	localparam int IDX_W  = 9;
	localparam int TOP_B  = 2 * fcd_pkg::FRAC_W;

	fcd_pkg::state_t state_q;

	logic [AW-1:0]   wp_q;
	logic [AW-1:0]   pos_q;
	logic [AW-1:0]   cnt_q;
	logic [TAPS-1:0] smp_vld_q;
	logic [TAPS-1:0] tap_vld_q;

	logic            in_fire;
	logic            is_sample;
	logic            coef_ok;
	logic [AW-1:0]   tap_addr;
	logic [AW-1:0]   wp_inc;
	logic [AW-1:0]   pos_inc;
	logic            cnt_last;
	logic            issue;

	logic [fcd_pkg::VALUE_W-1:0] smp_rd;
	logic [fcd_pkg::VALUE_W-1:0] tap_rd;

	logic                     rd_vld_s1;
	logic                     smp_ok_s1;
	logic                     tap_ok_s1;
	logic                     mul_vld_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;

	logic                               sat_hi;
	logic                               sat_lo;
	logic signed [fcd_pkg::VALUE_W-1:0] filt_d;
	logic                               load_out;
	logic                               out_vld_q;
	logic signed [fcd_pkg::VALUE_W-1:0] filt_q;
	logic                               sat_q;

	// request decode
	assign req.ready = (state_q == fcd_pkg::ST_IDLE);
	assign in_fire   = req.valid && req.ready;
	assign is_sample = (req.req_type == fcd_pkg::REQ_SAMPLE);
	assign coef_ok   = IDX_W'(req.tap_index) < IDX_W'(TAPS);
	assign tap_addr  = AW'(IDX_W'(req.tap_index));

	// circular pointer arithmetic
	assign wp_inc   = (wp_q == AW'(TAPS - 1)) ? '0 : wp_q + 1'b1;
	assign pos_inc  = (pos_q == AW'(TAPS - 1)) ? '0 : pos_q + 1'b1;
	assign cnt_last = (cnt_q == AW'(TAPS - 1));
	assign issue    = (state_q == fcd_pkg::ST_RUN);

	// delay line and coefficient storage
	fcd_ram #(.WIDTH(fcd_pkg::VALUE_W), .DEPTH(TAPS)) u_smp_ram (
		.clk   (clk),
		.we    (in_fire && is_sample),
		.waddr (wp_q),
		.wdata (req.value),
		.re    (issue),
		.raddr (pos_q),
		.rdata (smp_rd)
	);

	fcd_ram #(.WIDTH(fcd_pkg::VALUE_W), .DEPTH(TAPS)) u_tap_ram (
		.clk   (clk),
		.we    (in_fire && !is_sample && coef_ok),
		.waddr (tap_addr),
		.wdata (req.value),
		.re    (issue),
		.raddr (cnt_q),
		.rdata (tap_rd)
	);

	// valid bits: an entry never written reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_vld_q <= '0;
			tap_vld_q <= '0;
		end else if (in_fire) begin
			if (is_sample) begin
				smp_vld_q[wp_q] <= 1'b1;
			end else if (coef_ok) begin
				tap_vld_q[tap_addr] <= 1'b1;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fcd_pkg::ST_IDLE;
			wp_q    <= '0;
			pos_q   <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				fcd_pkg::ST_IDLE: begin
					if (in_fire && is_sample) begin
						wp_q    <= wp_inc;
						pos_q   <= wp_inc;
						cnt_q   <= '0;
						state_q <= fcd_pkg::ST_RUN;
					end
				end
				fcd_pkg::ST_RUN: begin
					pos_q <= pos_inc;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_last) begin
						state_q <= fcd_pkg::ST_DRAIN;
					end
				end
				fcd_pkg::ST_DRAIN: begin
					if (!rd_vld_s1 && !mul_vld_s2) begin
						state_q <= fcd_pkg::ST_DONE;
					end
				end
				fcd_pkg::ST_DONE: begin
					if (load_out) begin
						state_q <= fcd_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= fcd_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// stage 1: flags follow the RAM read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1  <= 1'b0;
			mul_vld_s2 <= 1'b0;
		end else begin
			rd_vld_s1  <= issue;
			mul_vld_s2 <= rd_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		smp_ok_s1 <= smp_vld_q[pos_q];
		tap_ok_s1 <= tap_vld_q[cnt_q];
	end

	// stage 2: shared multiplier, zero for entries never written
	always_ff @(posedge clk) begin
		if (smp_ok_s1 && tap_ok_s1) begin
			prod_s2 <= $signed(smp_rd) * $signed(tap_rd);
		end else begin
			prod_s2 <= '0;
		end
	end

	// accumulate; clear on each new sample
	always_ff @(posedge clk) begin
		if (in_fire && is_sample) begin
			acc_q <= '0;
		end else if (mul_vld_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	// floor shift by FRAC_W and saturate to Q1.15
	assign sat_hi = !acc_q[ACC_W-1] && (|acc_q[ACC_W-2:TOP_B]);
	assign sat_lo = acc_q[ACC_W-1] && !(&acc_q[ACC_W-2:TOP_B]);
	always_comb begin
		if (sat_hi) begin
			filt_d = fcd_pkg::Q_MAX;
		end else if (sat_lo) begin
			filt_d = fcd_pkg::Q_MIN;
		end else begin
			filt_d = acc_q[TOP_B:fcd_pkg::FRAC_W];
		end
	end

	// output register: load when free or being drained this cycle
	assign load_out = (state_q == fcd_pkg::ST_DONE) && (!out_vld_q || res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load_out) begin
			out_vld_q <= 1'b1;
		end else if (res.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			filt_q <= filt_d;
			sat_q  <= sat_hi || sat_lo;
		end
	end

	assign res.valid     = out_vld_q;
	assign res.filtered  = filt_q;
	assign res.saturated = sat_q;

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for fir_filter_circular_delay: a directed table, then random
// samples and coefficient writes under random source gaps and sink stalls.
// Depends on fcd_pkg, fcd_req_if, fcd_res_if and the filter RTL.
module testbench;

	localparam int NUM_TAPS     = 21;
	localparam int N_DIRECTED   = 22;
	localparam int N_RANDOM     = 1600;
	localparam int PRESSURE_AT  = 300;
	localparam int PRESSURE_LEN = 600;
	localparam int DRAIN_CYCLES = NUM_TAPS + 20;
	localparam int MAX_REPORTS  = 10;

	typedef struct packed {
		logic                               kind;
		logic [fcd_pkg::INDEX_W-1:0]        idx;
		logic signed [fcd_pkg::VALUE_W-1:0] val;
	} request_t;

	typedef struct packed {
		logic signed [fcd_pkg::VALUE_W-1:0] y;
		logic                               sat;
	} output_t;

	typedef struct packed {
		request_t req;
		logic     typed;
		output_t  want;
	} vector_t;

	logic clk;
	logic arst_n;

	fcd_req_if req_ch ();
	fcd_res_if res_ch ();

	fir_filter_circular_delay #(.TAPS(NUM_TAPS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch)
	);

	// Filter state mirrored on the testbench side
	logic signed [fcd_pkg::VALUE_W-1:0] sample_ring [NUM_TAPS];
	logic signed [fcd_pkg::VALUE_W-1:0] coef_bank   [NUM_TAPS];
	int                                 ring_ptr;
	output_t                            awaited_outputs [$];

	int mismatch_count;
	int samples_sent;
	int coef_writes;
	int dropped_writes;
	int results_checked;
	int clipped_seen;
	int burst_left;

	vector_t directed_rows [N_DIRECTED];

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Bound the run
	initial begin
		#10_000_000;
		$display("fir_filter_circular_delay regression: fail");
		$finish;
	end

	// Store a sample over the oldest entry and compute the shifted, saturated weighted sum
	function automatic output_t filter_sample(logic signed [fcd_pkg::VALUE_W-1:0] x);
		longint  acc;
		longint  shifted;
		int      p;
		output_t r;
		acc = 0;
		sample_ring[ring_ptr] = x;
		ring_ptr = (ring_ptr + 1 >= NUM_TAPS) ? 0 : ring_ptr + 1;
		p = ring_ptr;
		for (int i = 0; i < NUM_TAPS; i++) begin
			acc += longint'(sample_ring[p]) * longint'(coef_bank[i]);
			p = (p + 1 >= NUM_TAPS) ? 0 : p + 1;
		end
		shifted = acc >>> fcd_pkg::FRAC_W;
		r.sat = 1'b0;
		if (shifted > 32767) begin
			r.y   = fcd_pkg::Q_MAX;
			r.sat = 1'b1;
		end else if (shifted < -32768) begin
			r.y   = fcd_pkg::Q_MIN;
			r.sat = 1'b1;
		end else begin
			r.y = shifted[fcd_pkg::VALUE_W-1:0];
		end
		return r;
	endfunction

	// Offer one request, hold it until the transfer, then update the mirror
	task automatic send_request(request_t rq, logic typed, output_t want);
		output_t predicted;
		if (burst_left == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
			                                         : $urandom_range(1, 12);
		end
		burst_left--;
		req_ch.valid     <= 1'b1;
		req_ch.req_type  <= rq.kind;
		req_ch.tap_index <= rq.idx;
		req_ch.value     <= rq.val;
		do @(posedge clk); while (!req_ch.ready);
		if (rq.kind == fcd_pkg::REQ_COEF) begin
			if (rq.idx < NUM_TAPS) begin
				coef_bank[rq.idx] = rq.val;
				coef_writes++;
			end else begin
				dropped_writes++;
			end
		end else begin
			predicted = filter_sample(rq.val);
			awaited_outputs.push_back(typed ? want : predicted);
			samples_sent++;
		end
	endtask

	// Random value: extremes, zero, small magnitudes or full range
	function automatic logic signed [fcd_pkg::VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return fcd_pkg::Q_MAX;
			1:       return fcd_pkg::Q_MIN;
			2:       return '0;
			3, 4:    return fcd_pkg::VALUE_W'($signed($urandom_range(0, 511)) - 256);
			default: return fcd_pkg::VALUE_W'($urandom());
		endcase
	endfunction

	// Compare each result transfer with the oldest expectation
	always @(posedge clk) begin : check_results
		output_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (awaited_outputs.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("%0t: unexpected result filtered=%0d saturated=%0b",
						$realtime, res_ch.filtered, res_ch.saturated);
			end else begin
				want = awaited_outputs.pop_front();
				results_checked++;
				if (res_ch.saturated === 1'b1)
					clipped_seen++;
				if (res_ch.filtered !== want.y || res_ch.saturated !== want.sat) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display({"%0t: result %0d expected filtered=%0d saturated=%0b,",
							" got filtered=%0d saturated=%0b"},
							$realtime, results_checked, want.y, want.sat,
							res_ch.filtered, res_ch.saturated);
				end
			end
		end
	end

	// Sink stalls on modes of its own, with one long hold-off to back up the input
	initial begin : sink_side
		int  span;
		int  mode;
		int  hold_left;
		int  cyc;
		bit  pressure_done;
		span          = 0;
		mode          = 0;
		hold_left     = 0;
		cyc           = 0;
		pressure_done = 1'b0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (!pressure_done && samples_sent >= PRESSURE_AT) begin
				pressure_done = 1'b1;
				hold_left     = PRESSURE_LEN;
			end
			if (span == 0) begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(20, 200);
			end
			span--;
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				case (mode)
					0:       res_ch.ready <= 1'b1;
					1:       res_ch.ready <= ($urandom_range(0, 3) != 0);
					2:       res_ch.ready <= ($urandom_range(0, 9) < 3);
					default: res_ch.ready <= (cyc % 4 != 0);
				endcase
			end
		end
	end

	// Reset, directed table, random traffic, drain and verdict
	initial begin : source_side
		request_t rq;
		output_t  none;
		int       accepted;
		none             = '0;
		mismatch_count   = 0;
		samples_sent     = 0;
		coef_writes      = 0;
		dropped_writes   = 0;
		results_checked  = 0;
		clipped_seen     = 0;
		burst_left       = 0;
		ring_ptr         = 0;
		for (int i = 0; i < NUM_TAPS; i++) begin
			sample_ring[i] = '0;
			coef_bank[i]   = '0;
		end

		// Newest sample is weighted by tap 20, so the first rows read off directly
		directed_rows = '{
			'{'{fcd_pkg::REQ_SAMPLE, 5'd0,  16'sh7FFF}, 1'b1, '{16'sh0000, 1'b0}},
			'{'{fcd_pkg::REQ_SAMPLE, 5'd0,  16'sh8000}, 1'b1, '{16'sh0000, 1'b0}},
			'{'{fcd_pkg::REQ_COEF,   5'd20, 16'sh7FFF}, 1'b0, '{16'sh0000, 1'b0}},
			'{'{fcd_pkg::REQ_SAMPLE, 5'd0,  16'sh7FFF}, 1'b1, '{16'sh7FFE, 1'b0}},
			'{'{fcd_pkg::REQ_SAMPLE, 5'd0,  16'sh8000}, 1'b1, '{16'sh8001, 1'b0}},
			'{'{fcd_pkg::REQ_SAMPLE, 5'd0,  16'shFFFF}, 1'b1, '{16'shFFFF, 1'b0}},
			'{'{fcd_pkg::REQ_COEF,   5'd20, 16'sh8000}, 1'b0, '{16'sh0000, 1'b0}},
			'{'{fcd_pkg::REQ_SAMPLE, 5'd0,  16'sh8000}, 1'b1, '{16'sh7FFF, 1'b1}},
			'{'{fcd_pkg::REQ_SAMPLE, 5'd0,  16'sh7FFF}, 1'b1, '{16'sh8001, 1'b0}},
			'{'{fcd_pkg::REQ_COEF,   5'd19, 16'sh8000}, 1'b0, '{16'sh0000, 1'b0}},
			'{'{fcd_pkg::REQ_SAMPLE, 5'd0,  16'sh7FFF}, 1'b1, '{16'sh8000, 1'b1}},
			'{'{fcd_pkg::REQ_COEF,   5'd21, 16'sh1234}, 1'b0, '{16'sh0000, 1'b0}},
			'{'{fcd_pkg::REQ_COEF,   5'd31, 16'shFFFF}, 1'b0, '{16'sh0000, 1'b0}},
			'{'{fcd_pkg::REQ_SAMPLE, 5'd5,  16'sh0001}, 1'b0, '{16'sh0000, 1'b0}},
			'{'{fcd_pkg::REQ_COEF,   5'd0,  16'sh4000}, 1'b0, '{16'sh0000, 1'b0}},
			'{'{fcd_pkg::REQ_COEF,   5'd10, 16'shC000}, 1'b0, '{16'sh0000, 1'b0}},
			'{'{fcd_pkg::REQ_SAMPLE, 5'd31, 16'sh4000}, 1'b0, '{16'sh0000, 1'b0}},
			'{'{fcd_pkg::REQ_SAMPLE, 5'd0,  16'sh0000}, 1'b0, '{16'sh0000, 1'b0}},
			'{'{fcd_pkg::REQ_COEF,   5'd20, 16'sh0000}, 1'b0, '{16'sh0000, 1'b0}},
			'{'{fcd_pkg::REQ_COEF,   5'd19, 16'sh0000}, 1'b0, '{16'sh0000, 1'b0}},
			'{'{fcd_pkg::REQ_SAMPLE, 5'd0,  16'sh1234}, 1'b0, '{16'sh0000, 1'b0}},
			'{'{fcd_pkg::REQ_SAMPLE, 5'd0,  16'sh8000}, 1'b0, '{16'sh0000, 1'b0}}
		};

		arst_n           <= 1'b0;
		req_ch.valid     <= 1'b0;
		req_ch.req_type  <= fcd_pkg::REQ_SAMPLE;
		req_ch.tap_index <= '0;
		req_ch.value     <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		for (int r = 0; r < N_DIRECTED; r++)
			send_request(directed_rows[r].req, directed_rows[r].typed, directed_rows[r].want);

		// Random traffic; dropped coefficient writes do not count
		accepted = 0;
		while (accepted < N_RANDOM) begin
			if ($urandom_range(0, 3) == 0) begin
				rq.kind = fcd_pkg::REQ_COEF;
				if ($urandom_range(0, 9) == 0)
					rq.idx = fcd_pkg::INDEX_W'($urandom_range(21, 31));
				else
					rq.idx = fcd_pkg::INDEX_W'($urandom_range(0, 20));
			end else begin
				rq.kind = fcd_pkg::REQ_SAMPLE;
				rq.idx  = fcd_pkg::INDEX_W'($urandom_range(0, 31));
			end
			rq.val = pick_value();
			send_request(rq, 1'b0, none);
			if (!(rq.kind == fcd_pkg::REQ_COEF && rq.idx >= NUM_TAPS))
				accepted++;
		end
		req_ch.valid <= 1'b0;

		// Drain outstanding results, then let the pipeline settle
		while (awaited_outputs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d samples, %0d coefficient writes, %0d dropped tap writes.",
			samples_sent, coef_writes, dropped_writes);
		$display("Checked %0d results, %0d clipped, %0d mismatches.",
			results_checked, clipped_seen, mismatch_count);
		if (mismatch_count == 0 && awaited_outputs.size() == 0) begin
			$display("fir_filter_circular_delay regression: pass");
		end else begin
			$display("fir_filter_circular_delay regression: fail");
		end
		$finish;
	end

endmodule
